>>> sv/ufre_pkg.sv
// Package for the RFID UART frame extractor.
// Holds shared widths, defaults, function and status codes and the structs
// passed between the blocks. No dependencies.
package ufre_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int CARD_BYTES_DEF = 12;

  localparam int BYTE_W     = 8;
  localparam int SCAN_W     = 6;
  localparam int LEVEL_W    = 7;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_ADDR_W = 2;

  localparam logic [SCAN_W-1:0] SCAN_LEVEL_RST = SCAN_W'(20);
  localparam logic [BYTE_W-1:0] START_BYTE_RST = BYTE_W'(2);
  localparam logic [BYTE_W-1:0] STOP_BYTE_RST  = BYTE_W'(3);

  localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_LEVEL = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP_BYTE  = CFG_ADDR_W'(2);

  localparam logic [FUNC_W-1:0] FN_PUSH = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_SCAN = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_READ = FUNC_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_IDLE     = 3'd2,
    ST_CAPTURED = 3'd3,
    ST_DISCARD  = 3'd4,
    ST_NOCARD   = 3'd5,
    ST_CARDBYTE = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BODY,
    S_EMIT,
    S_RD_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [SCAN_W-1:0] scan_level;
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] stop_byte;
  } cfg_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
  } fifo_req_t;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [BYTE_W-1:0] wdata;
  } card_req_t;

endpackage

>>> sv/ufre_fifo.sv
// Receive byte ring FIFO: one synchronous memory with a registered read port,
// read and write pointers and a fill count. Depends on ufre_pkg.
module ufre_fifo
  import ufre_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int AW = $clog2(FIFO_DEPTH),
  localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_req_t         req,
  output logic [CW-1:0]     count,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]     wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [BYTE_W-1:0] rdata_r;

  // The controller never pushes and pops in the same cycle.
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (req.push) begin
      wr_idx_nxt = (wr_idx_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_r + AW'(1);
      count_nxt  = count_r + CW'(1);
    end else if (req.pop) begin
      rd_idx_nxt = (rd_idx_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_r + AW'(1);
      count_nxt  = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_idx_r] <= req.wdata;
    end
    if (req.pop) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  assign count = count_r;
  assign rdata = rdata_r;

endmodule

>>> sv/ufre_card.sv
// Card code store: a small synchronous memory with one write port and one
// registered read port that holds its data until the next read. Depends on ufre_pkg.
module ufre_card
  import ufre_pkg::*;
#(
  parameter int CARD_BYTES = CARD_BYTES_DEF,
  localparam int IW = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1
) (
  input  logic              clk,
  input  card_req_t         req,
  input  logic [IW-1:0]     waddr,
  input  logic [IW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [CARD_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ufre_ctrl.sv
// Sequencer for push, scan and card read items, with the pending mark and the
// output register. Drives the FIFO and card store ports. Depends on ufre_pkg.
module ufre_ctrl
  import ufre_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int CARD_BYTES = CARD_BYTES_DEF,
  localparam int CW = $clog2(FIFO_DEPTH + 1),
  localparam int IW = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1,
  localparam int PW = $clog2(CARD_BYTES + 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [BYTE_W-1:0]   out_card_byte,
  output logic                out_last,
  output logic [LEVEL_W-1:0]  out_level,
  output fifo_req_t           fifo_req,
  input  logic [CW-1:0]       fifo_count,
  input  logic [BYTE_W-1:0]   fifo_rdata,
  output card_req_t           card_req,
  output logic [IW-1:0]       card_waddr,
  output logic [IW-1:0]       card_raddr,
  input  logic [BYTE_W-1:0]   card_rdata
);

  localparam int LW = (CW > SCAN_W) ? CW : SCAN_W;

  ctrl_state_t         state_r, state_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [PW-1:0]       pop_cnt_r, pop_cnt_nxt;
  logic [PW-1:0]       take_r, take_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                pending_r, pending_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;

  logic in_fire, out_free, fifo_full, scan_go, need_pop, stop_here, dry;
  logic start_ok, card_last;

  always_comb begin
    in_fire   = in_valid && (state_r == S_IDLE);
    out_free  = !out_valid_r || out_ready;
    fifo_full = (fifo_count == CW'(FIFO_DEPTH));
    scan_go   = LW'(fifo_count) > LW'(cfg.scan_level);
    need_pop  = pop_cnt_r < PW'(CARD_BYTES + 1);
    // The closing byte is the one that arrives after all card bytes are taken.
    stop_here = rd_v_r && (take_r == PW'(CARD_BYTES));
    dry       = need_pop && (fifo_count == '0);
    start_ok  = (fifo_rdata == cfg.start_byte);
    card_last = (rd_idx_r == IW'(CARD_BYTES - 1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_PUSH: state_nxt = S_EMIT;
            FN_SCAN: state_nxt = scan_go ? S_START : S_EMIT;
            FN_READ: state_nxt = pending_r ? S_RD_OUT : S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_START:  state_nxt = start_ok ? S_BODY : S_EMIT;
      S_BODY: begin
        if (stop_here || dry) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (out_free && card_last) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_status_nxt = res_status_r;
    pop_cnt_nxt    = pop_cnt_r;
    take_nxt       = take_r;
    rd_v_nxt       = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    pending_nxt    = pending_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_level_nxt  = out_level_r;
    fifo_req       = '{push: 1'b0, pop: 1'b0, wdata: in_rx_byte};
    card_req       = '{wr: 1'b0, rd: 1'b0, wdata: fifo_rdata};
    card_waddr     = take_r[IW-1:0];
    card_raddr     = rd_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_PUSH: begin
              fifo_req.push  = !fifo_full;
              res_status_nxt = fifo_full ? ST_FULL : ST_PUSHED;
            end
            FN_SCAN: begin
              fifo_req.pop   = scan_go;
              res_status_nxt = ST_IDLE;
            end
            FN_READ: begin
              res_status_nxt = ST_NOCARD;
              pending_nxt    = 1'b0;
              card_req.rd    = pending_r;
              card_raddr     = '0;
              rd_idx_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        pop_cnt_nxt = '0;
        take_nxt    = '0;
        if (!start_ok) begin
          res_status_nxt = ST_DISCARD;
          pending_nxt    = 1'b0;
        end
      end
      S_BODY: begin
        if (rd_v_r && (take_r < PW'(CARD_BYTES))) begin
          card_req.wr = 1'b1;
          take_nxt    = take_r + PW'(1);
        end
        if (stop_here) begin
          if (fifo_rdata == cfg.stop_byte) begin
            res_status_nxt = ST_CAPTURED;
            pending_nxt    = 1'b1;
          end else begin
            res_status_nxt = ST_DISCARD;
            pending_nxt    = 1'b0;
          end
        end else if (dry) begin
          res_status_nxt = ST_DISCARD;
          pending_nxt    = 1'b0;
        end else if (need_pop) begin
          fifo_req.pop = 1'b1;
          pop_cnt_nxt  = pop_cnt_r + PW'(1);
          rd_v_nxt     = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_level_nxt  = LEVEL_W'(fifo_count);
        end
      end
      S_RD_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CARDBYTE;
          out_byte_nxt   = card_rdata;
          out_last_nxt   = card_last;
          out_level_nxt  = LEVEL_W'(fifo_count);
          if (!card_last) begin
            card_req.rd = 1'b1;
            card_raddr  = rd_idx_r + IW'(1);
            rd_idx_nxt  = rd_idx_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    pop_cnt_r    <= pop_cnt_nxt;
    take_r       <= take_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_level_r  <= out_level_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_card_byte = out_byte_r;
  assign out_last      = out_last_r;
  assign out_level     = out_level_r;

endmodule

>>> sv/uart_fifo_rfid_frame_extractor.sv
// RFID card frame extractor behind a UART receive FIFO.
// Input stream: in_tuser carries the function (push byte, scan tick, read
// card), in_tdata the received byte. Output stream: out_tuser carries the
// status, out_tdata the card byte and the FIFO level, out_tlast marks the
// final result of an item. Registers are written through cfg_we/cfg_addr.
// One item is worked on at a time; in_tready is high while the sequencer is
// idle, even when a result still waits in the output register.
// Push and no-card read: the emit state loads the result into the output register.
// Scan: the start state checks the start byte, then the body state takes the
// card bytes and closing byte, one a cycle via the FIFO registered read port.
// Card read: CARD_BYTES results via the card store read port, one a cycle
// while the receiver is ready. When the receiver stalls, the result holds in
// the output register and the sequencer waits before overwriting it.
// Synchronous reset empties the FIFO, clears the pending card and restores the
// register defaults; memory contents are not cleared and need no sweep.
// Depends on ufre_pkg, ufre_fifo, ufre_card and ufre_ctrl.
module uart_fifo_rfid_frame_extractor
  import ufre_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int CARD_BYTES = CARD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // rx_byte
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // card_byte, fifo_level, zero pad
  output logic [STATUS_W-1:0]   out_tuser,  // status
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int IW = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1;

  cfg_t              cfg_r, cfg_nxt;
  fifo_req_t         fifo_req;
  logic [CW-1:0]     fifo_count;
  logic [BYTE_W-1:0] fifo_rdata;
  card_req_t         card_req;
  logic [IW-1:0]     card_waddr, card_raddr;
  logic [BYTE_W-1:0] card_rdata;
  logic [BYTE_W-1:0] out_card_byte;
  logic [LEVEL_W-1:0] out_level;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SCAN_LEVEL: cfg_nxt.scan_level = cfg_wdata[SCAN_W-1:0];
        CFG_START_BYTE: cfg_nxt.start_byte = cfg_wdata;
        CFG_STOP_BYTE:  cfg_nxt.stop_byte  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scan_level: SCAN_LEVEL_RST, start_byte: START_BYTE_RST,
                 stop_byte: STOP_BYTE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ufre_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fifo_req),
    .count (fifo_count),
    .rdata (fifo_rdata)
  );

  ufre_card #(.CARD_BYTES(CARD_BYTES)) u_card (
    .clk   (clk),
    .req   (card_req),
    .waddr (card_waddr),
    .raddr (card_raddr),
    .rdata (card_rdata)
  );

  ufre_ctrl #(.FIFO_DEPTH(FIFO_DEPTH), .CARD_BYTES(CARD_BYTES)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_func       (in_tuser),
    .in_rx_byte    (in_tdata),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (out_tuser),
    .out_card_byte (out_card_byte),
    .out_last      (out_tlast),
    .out_level     (out_level),
    .fifo_req      (fifo_req),
    .fifo_count    (fifo_count),
    .fifo_rdata    (fifo_rdata),
    .card_req      (card_req),
    .card_waddr    (card_waddr),
    .card_raddr    (card_raddr),
    .card_rdata    (card_rdata)
  );

  assign out_tdata = {1'b0, out_level, out_card_byte};

endmodule

>>> bench/uart_fifo_rfid_frame_extractor_tb.sv
// Self-checking testbench for the UART FIFO RFID frame extractor.
// Drives push, scan and read items with random idling on both channels and
// checks each result against its predictor. Depends on ufre_pkg, the top.
module uart_fifo_rfid_frame_extractor_tb
  import ufre_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FN_UNUSED = FUNC_W'(3);
  localparam int DRAIN_CYCLES = 40;
  localparam int SINK_HOLD_CYCLES = 300;

  typedef enum int {
    FR_GOOD,
    FR_BAD_STOP,
    FR_BAD_START,
    FR_LONE_STOP,
    FR_SHORT
  } frame_kind_t;

  typedef struct packed {
    status_t              status;
    logic [BYTE_W-1:0]    card_byte;
    logic                 last;
    logic [LEVEL_W-1:0]   level;
  } rx_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;   // rx_byte
  logic [FUNC_W-1:0]     in_tuser;   // func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // card_byte, fifo_level, zero pad
  logic [STATUS_W-1:0]   out_tuser;  // status
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [BYTE_W-1:0]     cfg_wdata;

  // Predictor state.
  logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH_DEF];
  logic [BYTE_W-1:0] card_mem [CARD_BYTES_DEF];
  int                wr_ptr;
  int                rd_ptr;
  int                fill;
  logic              card_ready;
  logic [SCAN_W-1:0] lvl_reg;
  logic [BYTE_W-1:0] start_reg;
  logic [BYTE_W-1:0] stop_reg;

  rx_result_t  awaited_results [$];
  rx_result_t  want;
  int          error_count;
  int          items_sent;
  logic        idle_on;
  logic        sink_hold;

  uart_fifo_rfid_frame_extractor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void add_result(status_t st, logic [BYTE_W-1:0] cb, logic lst);
    rx_result_t r;
    r.status    = st;
    r.card_byte = cb;
    r.last      = lst;
    r.level     = LEVEL_W'(fill);
    awaited_results.push_back(r);
  endfunction

  function automatic logic [BYTE_W-1:0] fifo_pop_byte();
    logic [BYTE_W-1:0] b;
    b = fifo_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
    fill = fill - 1;
    return b;
  endfunction

  function automatic status_t frame_scan();
    logic ok;
    if (fill <= int'(lvl_reg)) return ST_IDLE;
    if (fifo_pop_byte() != start_reg) begin
      card_ready = 1'b0;
      return ST_DISCARD;
    end
    ok = 1'b1;
    for (int i = 0; i < CARD_BYTES_DEF; i++) begin
      if (ok) begin
        if (fill == 0) ok = 1'b0;
        else card_mem[i] = fifo_pop_byte();
      end
    end
    // The closing byte must be there and must match the stop byte.
    if (ok && fill == 0) ok = 1'b0;
    if (ok) ok = (fifo_pop_byte() == stop_reg);
    card_ready = ok;
    return ok ? ST_CAPTURED : ST_DISCARD;
  endfunction

  function automatic void frame_rx_predict(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] rx);
    status_t st;
    case (fn)
      FN_PUSH: begin
        if (fill >= FIFO_DEPTH_DEF) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          fifo_mem[wr_ptr] = rx;
          wr_ptr = (wr_ptr + 1) % FIFO_DEPTH_DEF;
          fill = fill + 1;
          add_result(ST_PUSHED, '0, 1'b1);
        end
      end
      FN_SCAN: begin
        st = frame_scan();
        add_result(st, '0, 1'b1);
      end
      FN_READ: begin
        if (!card_ready) begin
          add_result(ST_NOCARD, '0, 1'b1);
        end else begin
          card_ready = 1'b0;
          for (int i = 0; i < CARD_BYTES_DEF; i++)
            add_result(ST_CARDBYTE, card_mem[i], i == CARD_BYTES_DEF - 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d byte %02h last %0b level %0d",
                 $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[14:8]);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.status || out_tdata[7:0] !== want.card_byte ||
            out_tlast !== want.last || out_tdata[14:8] !== want.level ||
            out_tdata[15] !== 1'b0) begin
          $display("%0t: mismatch: expected status %0d byte %02h last %0b level %0d pad 0",
                   $time, want.status, want.card_byte, want.last, want.level);
          $display("%0t:          got status %0d byte %02h last %0b level %0d pad %0b",
                   $time, out_tuser, out_tdata[7:0], out_tlast, out_tdata[14:8],
                   out_tdata[15]);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] rx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= rx;
    do @(posedge clk); while (!in_tready);
    frame_rx_predict(fn, rx);
    if (fn != FN_UNUSED) items_sent++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // An ignored item may still be in flight after the last result.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [SCAN_W-1:0] lvl, logic [BYTE_W-1:0] sb,
                          logic [BYTE_W-1:0] eb);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SCAN_LEVEL;
    cfg_wdata <= BYTE_W'(lvl);
    @(posedge clk);
    cfg_addr  <= CFG_START_BYTE;
    cfg_wdata <= sb;
    @(posedge clk);
    cfg_addr  <= CFG_STOP_BYTE;
    cfg_wdata <= eb;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lvl_reg   = lvl;
    start_reg = sb;
    stop_reg  = eb;
  endtask

  task automatic send_frame(frame_kind_t kind);
    int n;
    if (kind == FR_LONE_STOP) send_item(FN_PUSH, stop_reg);
    if (kind == FR_BAD_START)
      send_item(FN_PUSH, start_reg ^ BYTE_W'($urandom_range(1, 255)));
    else
      send_item(FN_PUSH, start_reg);
    n = (kind == FR_SHORT) ? $urandom_range(1, CARD_BYTES_DEF - 1) : CARD_BYTES_DEF;
    repeat (n) send_item(FN_PUSH, BYTE_W'($urandom_range(0, 255)));
    if (kind == FR_BAD_STOP)
      send_item(FN_PUSH, stop_reg ^ BYTE_W'($urandom_range(1, 255)));
    else
      send_item(FN_PUSH, stop_reg);
  endtask

  // One round: a few frames, mostly well formed, then scans until the FIFO
  // drops to the scan level or six scans are sent, with reads mixed in.
  task automatic random_round();
    int scans;
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 2)) send_item(FN_PUSH, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0)
        send_item(FN_UNUSED, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        send_frame(frame_kind_t'($urandom_range(1, 4)));
      else
        send_frame(FR_GOOD);
    end
    scans = 0;
    do begin
      send_item(FN_SCAN, BYTE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 4) send_item(FN_READ, BYTE_W'($urandom_range(0, 255)));
      scans++;
    end while (fill > int'(lvl_reg) && scans < 6);
    if ($urandom_range(0, 1) == 0) send_item(FN_READ, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic random_phase(int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) random_round();
    wait_drain();
  endtask

  task automatic test_directed();
    logic [BYTE_W-1:0] body [CARD_BYTES_DEF] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                                  8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h3C, 8'hC3};
    set_regs(SCAN_W'(13), 8'h02, 8'h03);
    // A stray stop byte ahead of a good frame.
    send_item(FN_PUSH, stop_reg);
    send_item(FN_PUSH, start_reg);
    for (int i = 0; i < CARD_BYTES_DEF; i++) send_item(FN_PUSH, body[i]);
    send_item(FN_PUSH, stop_reg);
    send_item(FN_SCAN, 8'h00);
    send_item(FN_SCAN, 8'hFF);
    send_item(FN_READ, 8'h00);
    send_item(FN_READ, 8'hFF);
    send_item(FN_SCAN, 8'h00);
    send_item(FN_UNUSED, 8'hFF);
    wait_drain();
  endtask

  task automatic test_fifo_full();
    set_regs(SCAN_W'(63), 8'hFF, 8'h00);
    while (fill + CARD_BYTES_DEF + 2 <= FIFO_DEPTH_DEF) send_frame(FR_GOOD);
    while (fill < FIFO_DEPTH_DEF) send_item(FN_PUSH, BYTE_W'($urandom_range(0, 255)));
    repeat (3) send_item(FN_PUSH, BYTE_W'($urandom_range(0, 255)));
    send_item(FN_SCAN, 8'h00);
    send_item(FN_READ, 8'h00);
    send_item(FN_SCAN, 8'h00);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_regs(SCAN_W'(20), 8'h02, 8'h03);
    sink_hold = 1'b1;
    random_round();
    // Sender waits here until every result has come out.
    wait_drain();
  endtask

  task automatic test_random_settings();
    set_regs(SCAN_W'(13), 8'h00, 8'hFF);
    random_phase(10);
    set_regs(SCAN_W'($urandom_range(13, 63)), BYTE_W'($urandom_range(0, 255)),
             BYTE_W'($urandom_range(0, 255)));
    random_phase(10);
    set_regs(SCAN_W'(20), 8'h02, 8'h03);
    random_phase(10);
    // Last stretch without any idling.
    idle_on = 1'b0;
    set_regs(SCAN_W'(13), BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    random_phase(10);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FN_PUSH;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_SCAN_LEVEL;
    cfg_wdata   = '0;
    wr_ptr      = 0;
    rd_ptr      = 0;
    fill        = 0;
    card_ready  = 1'b0;
    lvl_reg     = SCAN_LEVEL_RST;
    start_reg   = START_BYTE_RST;
    stop_reg    = STOP_BYTE_RST;
    error_count = 0;
    items_sent  = 0;
    idle_on     = 1'b1;
    sink_hold   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fifo_full();
    test_backpressure();
    test_random_settings();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ufre_pkg.sv
sv/ufre_fifo.sv
sv/ufre_card.sv
sv/ufre_ctrl.sv
sv/uart_fifo_rfid_frame_extractor.sv
bench/uart_fifo_rfid_frame_extractor_tb.sv
